@@ src/delu_pkg.sv @@
// ============================================================================
// delu_pkg
// Shared types, widths and constant tables of the depth-dependent elastic
// property lookup: depth knots, velocity and density tables, reciprocals.
// ============================================================================
package delu_pkg;

   // Fixed-point format and table size
   localparam int FRAC_BITS    = 8;
   localparam int TABLE_POINTS = 10;
   localparam int SEGS         = TABLE_POINTS - 1;
   localparam int IDX_W        = 4;   // indexes the knot table
   localparam int SEG_W        = 4;   // indexes the segment tables

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // Datapath widths
   localparam int COORD_W     = 32;
   localparam int SUM_W       = COORD_W + 1;   // coordinate plus offset
   localparam int DEPTH_W     = COORD_W + 2;   // after negation
   localparam int KNOT_W      = DEPTH_W - 1;   // non-negative knot positions
   localparam int T_W         = 20;            // offset into one segment
   localparam int DY_W        = 10;            // table step of one segment
   localparam int DX_W        = 12;            // knot spacing, whole meters
   localparam int P_W         = DY_W + T_W;
   localparam int RECIP_SHIFT = 32;
   localparam int RECIP_W     = 24;
   localparam int PROD_W      = P_W + RECIP_W;
   localparam int Q_W         = PROD_W - RECIP_SHIFT;
   localparam int QDX_W       = Q_W + DX_W;
   localparam int V_W         = 21;            // widest interpolated value

   // Output field widths
   localparam int VP_W    = 21;
   localparam int VS_W    = 20;
   localparam int RHO_W   = 20;
   localparam int MU_W    = 36;
   localparam int LAM_W   = 37;
   localparam int VS2_W   = 2 * VS_W;
   localparam int VP2_W   = 2 * VP_W;
   localparam int SV2_W   = RHO_W + VS2_W;
   localparam int PV2_W   = RHO_W + VP2_W;
   localparam int MOD_SHIFT = 3 * FRAC_BITS;

   // Pipeline: three front stages, four lane stages, four modulus stages
   localparam int PIPE_STAGES = 11;

   localparam logic [SEG_W-1:0] SEG_ONE  = SEG_W'(1);
   localparam logic [SEG_W-1:0] SEG_LAST = SEG_W'(SEGS - 1);

   // Constant tables: knots in meters, velocities in m/s, density in kg/m^3
   localparam int unsigned DEPTH_TAB [TABLE_POINTS] =
      '{0, 500, 1000, 1600, 2400, 3600, 5000, 9000, 11000, 15000};
   localparam int unsigned VP_TAB [TABLE_POINTS] =
      '{2200, 3000, 3600, 4400, 4800, 5250, 5500, 5750, 6100, 6300};
   localparam int unsigned VS_TAB [TABLE_POINTS] =
      '{1050, 1400, 1950, 2500, 2800, 3100, 3250, 3450, 3600, 3700};
   localparam int unsigned RHO_TAB [TABLE_POINTS] =
      '{2200, 2450, 2550, 2600, 2600, 2620, 2650, 2720, 2750, 2900};

   // floor(2^RECIP_SHIFT / dx) for each segment
   localparam logic [RECIP_W-1:0] RECIP_TAB [SEGS] = '{
      RECIP_W'((64'd1 << RECIP_SHIFT) / (DEPTH_TAB[1] - DEPTH_TAB[0])),
      RECIP_W'((64'd1 << RECIP_SHIFT) / (DEPTH_TAB[2] - DEPTH_TAB[1])),
      RECIP_W'((64'd1 << RECIP_SHIFT) / (DEPTH_TAB[3] - DEPTH_TAB[2])),
      RECIP_W'((64'd1 << RECIP_SHIFT) / (DEPTH_TAB[4] - DEPTH_TAB[3])),
      RECIP_W'((64'd1 << RECIP_SHIFT) / (DEPTH_TAB[5] - DEPTH_TAB[4])),
      RECIP_W'((64'd1 << RECIP_SHIFT) / (DEPTH_TAB[6] - DEPTH_TAB[5])),
      RECIP_W'((64'd1 << RECIP_SHIFT) / (DEPTH_TAB[7] - DEPTH_TAB[6])),
      RECIP_W'((64'd1 << RECIP_SHIFT) / (DEPTH_TAB[8] - DEPTH_TAB[7])),
      RECIP_W'((64'd1 << RECIP_SHIFT) / (DEPTH_TAB[9] - DEPTH_TAB[8]))
   };

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_DEPTH_AXIS   = 2'd0,
      CSR_DEPTH_OFFSET = 2'd1,
      CSR_CLAMP        = 2'd2,
      CSR_FLIP         = 2'd3
   } csr_index_type;

   // Axis codes; the unused code selects z
   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   // Interpolation lanes
   typedef enum logic [1:0] {
      LANE_VP  = 2'd0,
      LANE_VS  = 2'd1,
      LANE_RHO = 2'd2
   } lane_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
   } req_type;

   typedef struct packed {
      logic [VP_W-1:0]  p_velocity;
      logic [VS_W-1:0]  s_velocity;
      logic [RHO_W-1:0] density;
      logic [MU_W-1:0]  shear_modulus;
      logic [LAM_W-1:0] lame_lambda;
   } rsp_type;

   // One interpolation beat: segment, offset into it, step and base value
   typedef struct packed {
      logic [SEG_W-1:0] seg;
      logic [T_W-1:0]   t;
      logic [DY_W-1:0]  dy;
      logic [V_W-1:0]   y0s;
   } lane_in_type;

   typedef logic [KNOT_W-1:0] knot_arr_type [TABLE_POINTS];

   // Knot positions in Q.FRAC_BITS meters
   function automatic knot_arr_type make_knots();
      knot_arr_type k;
      for (int i = 0; i < TABLE_POINTS; i++) begin
         k[i] = KNOT_W'(DEPTH_TAB[i]) << FRAC_BITS;
      end
      return k;
   endfunction

   localparam knot_arr_type KNOT_Q = make_knots();

   // Knot spacing of a segment, whole meters
   function automatic logic [DX_W-1:0] dx_of(input logic [SEG_W-1:0] seg);
      return DX_W'(DEPTH_TAB[seg + SEG_ONE] - DEPTH_TAB[seg]);
   endfunction

   // Table step over a segment
   function automatic logic [DY_W-1:0] dy_of(input lane_type lane,
                                             input logic [SEG_W-1:0] seg);
      logic [DY_W-1:0] dy;
      unique case (lane)
         LANE_VP:  dy = DY_W'(VP_TAB[seg + SEG_ONE] - VP_TAB[seg]);
         LANE_VS:  dy = DY_W'(VS_TAB[seg + SEG_ONE] - VS_TAB[seg]);
         LANE_RHO: dy = DY_W'(RHO_TAB[seg + SEG_ONE] - RHO_TAB[seg]);
         default:  dy = '0;
      endcase
      return dy;
   endfunction

   // Base value of a segment in Q.FRAC_BITS
   function automatic logic [V_W-1:0] y0s_of(input lane_type lane,
                                             input logic [SEG_W-1:0] seg);
      logic [V_W-1:0] y;
      unique case (lane)
         LANE_VP:  y = V_W'(VP_TAB[seg] << FRAC_BITS);
         LANE_VS:  y = V_W'(VS_TAB[seg] << FRAC_BITS);
         LANE_RHO: y = V_W'(RHO_TAB[seg] << FRAC_BITS);
         default:  y = '0;
      endcase
      return y;
   endfunction

endpackage

@@ src/delu_interp_lane.sv @@
// ============================================================================
// delu_interp_lane
// Four-stage interpolation lane: y0 + floor(dy * t / dx), with the division
// done as a reciprocal multiply and one correction step.
// ============================================================================
module delu_interp_lane (
   input  logic                        clock,
   input  delu_pkg::lane_in_type       lane_in,
   output logic [delu_pkg::V_W-1:0]    lane_value
);

   // Stage 1: numerator
   logic [delu_pkg::P_W-1:0]   p1_ff, p1_in;
   logic [delu_pkg::SEG_W-1:0] seg1_ff;
   logic [delu_pkg::V_W-1:0]   y0s1_ff;

   // Stage 2: estimated quotient
   logic [delu_pkg::PROD_W-1:0] prod2;
   logic [delu_pkg::Q_W-1:0]    qest2_ff, qest2_in;
   logic [delu_pkg::P_W-1:0]    p2_ff;
   logic [delu_pkg::SEG_W-1:0]  seg2_ff;
   logic [delu_pkg::V_W-1:0]    y0s2_ff;

   // Stage 3: quotient times divisor
   logic [delu_pkg::QDX_W-1:0] qdx3_ff, qdx3_in;
   logic [delu_pkg::Q_W-1:0]   qest3_ff;
   logic [delu_pkg::P_W-1:0]   p3_ff;
   logic [delu_pkg::SEG_W-1:0] seg3_ff;
   logic [delu_pkg::V_W-1:0]   y0s3_ff;

   // Stage 4: correction and base add
   logic [delu_pkg::QDX_W-1:0] rem4;
   logic [delu_pkg::Q_W-1:0]   q4;
   logic [delu_pkg::Q_W-1:0]   sum4;
   logic [delu_pkg::V_W-1:0]   value_ff, value_in;

   // Form the numerator dy * t
   assign p1_in = lane_in.dy * lane_in.t;

   always_ff @(posedge clock) begin
      p1_ff   <= p1_in;
      seg1_ff <= lane_in.seg;
      y0s1_ff <= lane_in.y0s;
   end

   // Multiply by the segment reciprocal; the estimate is low by at most one
   assign prod2    = p1_ff * delu_pkg::RECIP_TAB[seg1_ff];
   assign qest2_in = prod2[delu_pkg::PROD_W-1:delu_pkg::RECIP_SHIFT];

   always_ff @(posedge clock) begin
      qest2_ff <= qest2_in;
      p2_ff    <= p1_ff;
      seg2_ff  <= seg1_ff;
      y0s2_ff  <= y0s1_ff;
   end

   // Multiply the estimate back by the divisor
   assign qdx3_in = qest2_ff * delu_pkg::dx_of(seg2_ff);

   always_ff @(posedge clock) begin
      qdx3_ff  <= qdx3_in;
      qest3_ff <= qest2_ff;
      p3_ff    <= p2_ff;
      seg3_ff  <= seg2_ff;
      y0s3_ff  <= y0s2_ff;
   end

   // Bump the quotient when the remainder reaches the divisor, then add base
   always_comb begin
      rem4 = {{(delu_pkg::QDX_W - delu_pkg::P_W){1'b0}}, p3_ff} - qdx3_ff;
      q4   = qest3_ff;
      if (rem4 >= {{(delu_pkg::QDX_W - delu_pkg::DX_W){1'b0}},
                   delu_pkg::dx_of(seg3_ff)}) begin
         q4 = qest3_ff + {{(delu_pkg::Q_W - 1){1'b0}}, 1'b1};
      end
      sum4     = {{(delu_pkg::Q_W - delu_pkg::V_W){1'b0}}, y0s3_ff} + q4;
      value_in = sum4[delu_pkg::V_W-1:0];
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign lane_value = value_ff;

endmodule

@@ src/depth_elastic_property_lookup_unit.sv @@
// ============================================================================
// depth_elastic_property_lookup_unit
// Depth-dependent elastic properties: picks the depth coordinate, applies
// offset, sign and clamp, interpolates Vp, Vs and density over a fixed depth
// table and forms shear modulus and Lame lambda in whole pascals.
// ============================================================================
//
// Channel   Ports                                   Beat taken when
// -------   -------------------------------------   -------------------------
// request   start, busy, req_data                   start && !busy
// response  rsp_strobe, rsp_data                    rsp_strobe (one cycle)
// csr       csr_we, csr_index, csr_wdata            csr_we
//
// One point per cycle sustained. The pipeline is three depth stages, four
// interpolation stages (three multiplies and a correction), and four modulus
// stages. busy follows reset; reset clears the valid bits and loads the
// register defaults.
// The response side cannot stall, so the pipeline always advances.
//
module depth_elastic_property_lookup_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  delu_pkg::req_type                  req_data,
   output logic                               rsp_strobe,
   output delu_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [delu_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [delu_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // Configuration registers
   logic [1:0]                        axis_ff;
   logic [delu_pkg::COORD_W-1:0]      offset_ff;
   logic                              clamp_ff;
   logic                              flip_ff;

   // Valid bits, one per stage
   logic [delu_pkg::PIPE_STAGES-1:0]  valid_ff, valid_in;
   logic                              accept;

   // Front stages
   logic signed [delu_pkg::COORD_W-1:0] coord_sel;
   logic signed [delu_pkg::SUM_W-1:0]   sum1_ff, sum1_in;
   logic signed [delu_pkg::DEPTH_W-1:0] d_ext, d_raw;
   logic signed [delu_pkg::DEPTH_W-1:0] d2_ff, d2_in;
   logic                                below3, above3;
   logic [delu_pkg::SEG_W-1:0]          cnt3;
   logic [delu_pkg::KNOT_W-1:0]         diff3;
   logic [delu_pkg::SEG_W-1:0]          seg3_ff, seg3_in;
   logic [delu_pkg::T_W-1:0]            t3_ff, t3_in;
   logic [delu_pkg::KNOT_W-1:0]         last_dx;

   // Lanes
   delu_pkg::lane_in_type               vp_lane_in, vs_lane_in, rho_lane_in;
   logic [delu_pkg::V_W-1:0]            vp7, vs7, rho7;

   // Modulus stages
   logic [delu_pkg::VP_W-1:0]   vp8_ff, vp9_ff, vp10_ff;
   logic [delu_pkg::VS_W-1:0]   vs8_ff, vs9_ff, vs10_ff;
   logic [delu_pkg::RHO_W-1:0]  rho8_ff, rho9_ff, rho10_ff;
   logic [delu_pkg::VS2_W-1:0]  vs2_8_ff, vs2_8_in;
   logic [delu_pkg::VP2_W-1:0]  vp2_8_ff, vp2_8_in;
   logic [delu_pkg::RHO_W+delu_pkg::VS_W-1:0] smu_lo9_ff, smu_hi9_ff;
   logic [delu_pkg::RHO_W+delu_pkg::VP_W-1:0] slp_lo9_ff, slp_hi9_ff;
   logic [delu_pkg::SV2_W-1:0]  sv2_10_ff, sv2_10_in;
   logic [delu_pkg::PV2_W-1:0]  pv2_10_ff, pv2_10_in;
   logic [delu_pkg::PV2_W-1:0]  twice_sv2, lam_diff;
   delu_pkg::rsp_type           rsp_ff, rsp_in;

   // Handshake
   assign busy   = reset;
   assign accept = start && !busy;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff   <= delu_pkg::AXIS_Y;
         offset_ff <= '0;
         clamp_ff  <= 1'b1;
         flip_ff   <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            delu_pkg::CSR_DEPTH_AXIS:   axis_ff   <= csr_wdata[1:0];
            delu_pkg::CSR_DEPTH_OFFSET: offset_ff <= csr_wdata;
            delu_pkg::CSR_CLAMP:        clamp_ff  <= csr_wdata[0];
            delu_pkg::CSR_FLIP:         flip_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Advance valid bits with the data
   assign valid_in = {valid_ff[delu_pkg::PIPE_STAGES-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Stage 1: select the depth coordinate and add the offset at full width
   always_comb begin
      unique case (axis_ff)
         delu_pkg::AXIS_X: coord_sel = req_data.coord_x;
         delu_pkg::AXIS_Y: coord_sel = req_data.coord_y;
         default:          coord_sel = req_data.coord_z;
      endcase
      sum1_in = $signed({coord_sel[delu_pkg::COORD_W-1], coord_sel})
              + $signed({offset_ff[delu_pkg::COORD_W-1], offset_ff});
   end

   always_ff @(posedge clock) begin
      sum1_ff <= sum1_in;
   end

   // Stage 2: negate when flipped, clamp non-positive depths when clamp is set
   always_comb begin
      d_ext = {sum1_ff[delu_pkg::SUM_W-1], sum1_ff};
      d_raw = flip_ff ? -d_ext : d_ext;
      d2_in = d_raw;
      if (clamp_ff && (d_raw[delu_pkg::DEPTH_W-1] || d_raw == '0)) begin
         d2_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      d2_ff <= d2_in;
   end

   // Stage 3: find the segment and the offset into it; hold end values
   assign last_dx = delu_pkg::KNOT_Q[delu_pkg::TABLE_POINTS-1]
                  - delu_pkg::KNOT_Q[delu_pkg::TABLE_POINTS-2];

   always_comb begin
      below3 = d2_ff[delu_pkg::DEPTH_W-1] || (d2_ff == '0);
      above3 = !d2_ff[delu_pkg::DEPTH_W-1]
            && (d2_ff[delu_pkg::KNOT_W-1:0]
                >= delu_pkg::KNOT_Q[delu_pkg::TABLE_POINTS-1]);
      cnt3 = '0;
      for (int k = 1; k < delu_pkg::TABLE_POINTS - 1; k++) begin
         if (d2_ff[delu_pkg::KNOT_W-1:0] > delu_pkg::KNOT_Q[k]) begin
            cnt3 = cnt3 + delu_pkg::SEG_ONE;
         end
      end
      diff3 = d2_ff[delu_pkg::KNOT_W-1:0] - delu_pkg::KNOT_Q[cnt3];
      priority if (below3) begin
         seg3_in = '0;
         t3_in   = '0;
      end else if (above3) begin
         seg3_in = delu_pkg::SEG_LAST;
         t3_in   = last_dx[delu_pkg::T_W-1:0];
      end else begin
         seg3_in = cnt3;
         t3_in   = diff3[delu_pkg::T_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      seg3_ff <= seg3_in;
      t3_ff   <= t3_in;
   end

   // Stages 4 to 7: three interpolation lanes share segment and offset
   always_comb begin
      vp_lane_in.seg  = seg3_ff;
      vp_lane_in.t    = t3_ff;
      vp_lane_in.dy   = delu_pkg::dy_of(delu_pkg::LANE_VP, seg3_ff);
      vp_lane_in.y0s  = delu_pkg::y0s_of(delu_pkg::LANE_VP, seg3_ff);
      vs_lane_in.seg  = seg3_ff;
      vs_lane_in.t    = t3_ff;
      vs_lane_in.dy   = delu_pkg::dy_of(delu_pkg::LANE_VS, seg3_ff);
      vs_lane_in.y0s  = delu_pkg::y0s_of(delu_pkg::LANE_VS, seg3_ff);
      rho_lane_in.seg = seg3_ff;
      rho_lane_in.t   = t3_ff;
      rho_lane_in.dy  = delu_pkg::dy_of(delu_pkg::LANE_RHO, seg3_ff);
      rho_lane_in.y0s = delu_pkg::y0s_of(delu_pkg::LANE_RHO, seg3_ff);
   end

   delu_interp_lane u_vp_lane (
      .clock      (clock),
      .lane_in    (vp_lane_in),
      .lane_value (vp7)
   );

   delu_interp_lane u_vs_lane (
      .clock      (clock),
      .lane_in    (vs_lane_in),
      .lane_value (vs7)
   );

   delu_interp_lane u_rho_lane (
      .clock      (clock),
      .lane_in    (rho_lane_in),
      .lane_value (rho7)
   );

   // Stage 8: square the velocities
   assign vs2_8_in = vs7[delu_pkg::VS_W-1:0] * vs7[delu_pkg::VS_W-1:0];
   assign vp2_8_in = vp7[delu_pkg::VP_W-1:0] * vp7[delu_pkg::VP_W-1:0];

   always_ff @(posedge clock) begin
      vs2_8_ff <= vs2_8_in;
      vp2_8_ff <= vp2_8_in;
      vp8_ff   <= vp7[delu_pkg::VP_W-1:0];
      vs8_ff   <= vs7[delu_pkg::VS_W-1:0];
      rho8_ff  <= rho7[delu_pkg::RHO_W-1:0];
   end

   // Stage 9: density times each half of the squares
   always_ff @(posedge clock) begin
      smu_lo9_ff <= rho8_ff * vs2_8_ff[delu_pkg::VS_W-1:0];
      smu_hi9_ff <= rho8_ff * vs2_8_ff[delu_pkg::VS2_W-1:delu_pkg::VS_W];
      slp_lo9_ff <= rho8_ff * vp2_8_ff[delu_pkg::VP_W-1:0];
      slp_hi9_ff <= rho8_ff * vp2_8_ff[delu_pkg::VP2_W-1:delu_pkg::VP_W];
      vp9_ff     <= vp8_ff;
      vs9_ff     <= vs8_ff;
      rho9_ff    <= rho8_ff;
   end

   // Stage 10: merge the partial products
   assign sv2_10_in = {{delu_pkg::VS_W{1'b0}}, smu_lo9_ff}
                    + {smu_hi9_ff, {delu_pkg::VS_W{1'b0}}};
   assign pv2_10_in = {{delu_pkg::VP_W{1'b0}}, slp_lo9_ff}
                    + {slp_hi9_ff, {delu_pkg::VP_W{1'b0}}};

   always_ff @(posedge clock) begin
      sv2_10_ff <= sv2_10_in;
      pv2_10_ff <= pv2_10_in;
      vp10_ff   <= vp9_ff;
      vs10_ff   <= vs9_ff;
      rho10_ff  <= rho9_ff;
   end

   // Stage 11: truncate to whole pascals, floor lambda at zero
   always_comb begin
      twice_sv2 = {{(delu_pkg::PV2_W - delu_pkg::SV2_W - 1){1'b0}}, sv2_10_ff, 1'b0};
      lam_diff  = pv2_10_ff - twice_sv2;
      rsp_in.p_velocity    = vp10_ff;
      rsp_in.s_velocity    = vs10_ff;
      rsp_in.density       = rho10_ff;
      rsp_in.shear_modulus = sv2_10_ff[delu_pkg::MOD_SHIFT +: delu_pkg::MU_W];
      rsp_in.lame_lambda   = '0;
      if (pv2_10_ff > twice_sv2) begin
         rsp_in.lame_lambda = lam_diff[delu_pkg::MOD_SHIFT +: delu_pkg::LAM_W];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_data   = rsp_ff;
   assign rsp_strobe = valid_ff[delu_pkg::PIPE_STAGES-1];

   // Each result beat traces back to a request beat a fixed latency earlier
   a_strobe_follows_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, delu_pkg::PIPE_STAGES))
      else $error("result beat without a matching request beat");

   // Every request beat yields a result beat a fixed latency later
   a_beat_yields_strobe: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(delu_pkg::PIPE_STAGES) rsp_strobe)
      else $error("request beat lost in the pipeline");

   // Reset drops anything in flight
   a_reset_flushes: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result beat right after reset");

   // Interpolated P speed stays between the table end values
   a_vp_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |->
         (rsp_data.p_velocity >= delu_pkg::VP_W'(delu_pkg::VP_TAB[0]
                                 << delu_pkg::FRAC_BITS)) &&
         (rsp_data.p_velocity <= delu_pkg::VP_W'(delu_pkg::VP_TAB[delu_pkg::TABLE_POINTS-1]
                                 << delu_pkg::FRAC_BITS)))
      else $error("P speed outside the table range");

endmodule

@@ test/delu_property_checker.sv @@
// ============================================================================
// delu_property_checker
// Watches the request, response and csr channels of the depth-dependent
// elastic property lookup, predicts every result from the accepted request
// beats and the current register settings, and compares each response beat
// in order against the oldest prediction.
// ============================================================================
module delu_property_checker
   import delu_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  req_type                req_data,
   input  logic                   rsp_strobe,
   input  rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     outstanding,
   output int                     fault_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint ONE_Q = longint'(1) << FRAC_BITS;

   // Depth knots in meters and the properties at each knot
   localparam longint KNOT_M [TABLE_POINTS] =
      '{0, 500, 1000, 1600, 2400, 3600, 5000, 9000, 11000, 15000};
   localparam longint VP_MS [TABLE_POINTS] =
      '{2200, 3000, 3600, 4400, 4800, 5250, 5500, 5750, 6100, 6300};
   localparam longint VS_MS [TABLE_POINTS] =
      '{1050, 1400, 1950, 2500, 2800, 3100, 3250, 3450, 3600, 3700};
   localparam longint RHO_KGM [TABLE_POINTS] =
      '{2200, 2450, 2550, 2600, 2600, 2620, 2650, 2720, 2750, 2900};

   // Shadow copy of the csr settings
   logic [1:0]         axis_sel;
   logic signed [31:0] offset_q;
   logic               clamp_on;
   logic               flip_on;

   rsp_type props_due [$];
   int      faults = 0;

   function automatic longint table_entry(input lane_type lane, input int i);
      case (lane)
         LANE_VP: return VP_MS[i];
         LANE_VS: return VS_MS[i];
         default: return RHO_KGM[i];
      endcase
   endfunction

   // Linear interpolation over the knot table, end values held outside it
   function automatic longint interp_lane(input lane_type lane, input longint depth_q);
      longint x0;
      longint x1;
      longint dy;
      if (depth_q <= KNOT_M[0] * ONE_Q)
         return table_entry(lane, 0) * ONE_Q;
      if (depth_q >= KNOT_M[TABLE_POINTS-1] * ONE_Q)
         return table_entry(lane, TABLE_POINTS - 1) * ONE_Q;
      for (int i = 0; i < TABLE_POINTS - 1; i++) begin
         x0 = KNOT_M[i] * ONE_Q;
         x1 = KNOT_M[i+1] * ONE_Q;
         if (depth_q >= x0 && depth_q <= x1) begin
            dy = table_entry(lane, i + 1) - table_entry(lane, i);
            return table_entry(lane, i) * ONE_Q
                   + (dy * (depth_q - x0)) / (KNOT_M[i+1] - KNOT_M[i]);
         end
      end
      return table_entry(lane, TABLE_POINTS - 1) * ONE_Q;
   endfunction

   // Depth selection, interpolation and moduli for one point
   function automatic rsp_type elastic_props(input req_type pt);
      logic signed [31:0] coord;
      longint             depth;
      logic [63:0]        vp;
      logic [63:0]        vs;
      logic [63:0]        rho;
      logic [63:0]        sv2;
      logic [63:0]        pv2;
      rsp_type            r;
      case (axis_sel)
         AXIS_X:  coord = pt.coord_x;
         AXIS_Y:  coord = pt.coord_y;
         default: coord = pt.coord_z;   // z and the spare code
      endcase
      // full precision, no wrap
      depth = longint'(coord) + longint'(offset_q);
      if (flip_on)
         depth = -depth;
      if (clamp_on && depth <= 0)
         depth = 0;
      vp  = interp_lane(LANE_VP, depth);
      vs  = interp_lane(LANE_VS, depth);
      rho = interp_lane(LANE_RHO, depth);
      sv2 = rho * vs * vs;
      pv2 = rho * vp * vp;
      r.p_velocity    = VP_W'(vp);
      r.s_velocity    = VS_W'(vs);
      r.density       = RHO_W'(rho);
      r.shear_modulus = MU_W'(sv2 >> MOD_SHIFT);
      r.lame_lambda   = (pv2 > 2 * sv2) ? LAM_W'((pv2 - 2 * sv2) >> MOD_SHIFT) : '0;
      return r;
   endfunction

   // Check response beats, queue predictions, then track csr writes
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         axis_sel = AXIS_Y;
         offset_q = '0;
         clamp_on = 1'b1;
         flip_on  = 1'b0;
         props_due.delete();
      end else begin
         if (rsp_strobe) begin
            if (props_due.size() == 0) begin
               if (faults < 10)
                  $display("%t unexpected result: vp=%0d vs=%0d rho=%0d mu=%0d lam=%0d",
                           $realtime, rsp_data.p_velocity, rsp_data.s_velocity,
                           rsp_data.density, rsp_data.shear_modulus, rsp_data.lame_lambda);
               faults++;
            end else begin
               want = props_due.pop_front();
               if (want.p_velocity !== rsp_data.p_velocity ||
                   want.s_velocity !== rsp_data.s_velocity ||
                   want.density !== rsp_data.density ||
                   want.shear_modulus !== rsp_data.shear_modulus ||
                   want.lame_lambda !== rsp_data.lame_lambda) begin
                  if (faults < 10) begin
                     $display("%t mismatch: expected vp=%0d vs=%0d rho=%0d mu=%0d lam=%0d",
                              $realtime, want.p_velocity, want.s_velocity, want.density,
                              want.shear_modulus, want.lame_lambda);
                     $display("%t             actual vp=%0d vs=%0d rho=%0d mu=%0d lam=%0d",
                              $realtime, rsp_data.p_velocity, rsp_data.s_velocity,
                              rsp_data.density, rsp_data.shear_modulus,
                              rsp_data.lame_lambda);
                  end
                  faults++;
               end
            end
         end
         // predict with the settings in force at this edge
         if (start && !busy)
            props_due.push_back(elastic_props(req_data));
         if (csr_we) begin
            case (csr_index)
               CSR_DEPTH_AXIS:   axis_sel = csr_wdata[1:0];
               CSR_DEPTH_OFFSET: offset_q = csr_wdata;
               CSR_CLAMP:        clamp_on = csr_wdata[0];
               CSR_FLIP:         flip_on  = csr_wdata[0];
               default: ;
            endcase
         end
      end
      outstanding <= props_due.size();
      fault_count <= faults;
   end

endmodule

@@ test/depth_elastic_property_lookup_unit_test.sv @@
// ============================================================================
// depth_elastic_property_lookup_unit_test
// Drives points into the depth-dependent elastic property lookup in random
// bursts under a series of csr settings (every axis code, offset extremes,
// clamp and sign flip on and off) and reports the checker's verdict.
// ============================================================================
module depth_elastic_property_lookup_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import delu_pkg::*;

   localparam int         STALL_LIMIT      = 1000;
   localparam int         PHASES           = 10;
   localparam int         POINTS_PER_PHASE = 63;
   localparam logic [1:0] AXIS_SPARE       = 2'd3;
   localparam int         KNOT_M [TABLE_POINTS] =
      '{0, 500, 1000, 1600, 2400, 3600, 5000, 9000, 11000, 15000};

   // Depths along y under reset settings: extremes, knots, table ends
   localparam int DIRECTED_Y [19] = '{
      0, -1, 1, -2147483647 - 1, 2147483647,
      500 * 256, 1000 * 256, 1600 * 256, 2400 * 256, 3600 * 256,
      5000 * 256, 9000 * 256, 11000 * 256,
      15000 * 256 - 1, 15000 * 256, 15000 * 256 + 1,
      250 * 256 + 128, 7000 * 256 + 77, 12345 * 256 + 255
   };
   // z under the spare axis code, minimum offset and sign flip: wide depths
   localparam int DIRECTED_Z [4] = '{-2147483647 - 1, 2147483647, 0, -1};

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   req_type                req_data;
   logic                   rsp_strobe;
   rsp_type                rsp_data;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   int outstanding;
   int fault_count;
   int burst_left   = 0;
   bit steady       = 1'b0;
   int stall_cycles = 0;

   depth_elastic_property_lookup_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   delu_property_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .outstanding (outstanding),
      .fault_count (fault_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: end the run when no channel moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_we)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Hold one request beat until taken, then maybe pause between bursts
   task automatic issue(input req_type pt);
      int gap;
      start    <= 1'b1;
      req_data <= pt;
      do @(posedge clock); while (busy);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 24);
         if (steady)
            gap = 0;
         else if ($urandom_range(0, 7) == 0)
            gap = $urandom_range(8, 40);
         else
            gap = $urandom_range(0, 4);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Drop start and wait until every predicted result has come back
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic csr_beat(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Write all four registers; junk fills the unused upper bits
   task automatic write_settings(input logic [1:0] axis, input logic [31:0] offset,
                                 input bit clamp, input bit flip,
                                 input logic [31:0] junk);
      csr_beat(CSR_DEPTH_AXIS, {junk[31:2], axis});
      csr_beat(CSR_DEPTH_OFFSET, offset);
      csr_beat(CSR_CLAMP, {junk[31:1], clamp});
      csr_beat(CSR_FLIP, {junk[31:1], flip});
      csr_we <= 1'b0;
   endtask

   // Random point whose depth coordinate mostly lands inside the table
   function automatic req_type random_point(input logic [1:0] axis,
                                            input logic signed [31:0] offset,
                                            input bit flip);
      req_type    pt;
      int         pick;
      longint     target;
      longint     raw;
      logic [31:0] c;
      pt.coord_x = $urandom;
      pt.coord_y = $urandom;
      pt.coord_z = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
         if (pick < 50)
            target = $urandom_range(0, 15500 * 256);
         else if (pick < 65)
            target = longint'(KNOT_M[$urandom_range(0, TABLE_POINTS - 1)]) * 256
                     + $urandom_range(0, 2) - 1;
         else
            target = -longint'($urandom_range(0, 4096));
         raw = (flip ? -target : target) - longint'(offset);
         c   = raw[31:0];
      end else if (pick < 85) begin
         case ($urandom_range(0, 3))
            0:       c = 32'h8000_0000;
            1:       c = 32'h7FFF_FFFF;
            2:       c = 32'h0000_0000;
            default: c = 32'hFFFF_FFFF;
         endcase
      end else begin
         c = $urandom;
      end
      case (axis)
         AXIS_X:  pt.coord_x = c;
         AXIS_Y:  pt.coord_y = c;
         default: pt.coord_z = c;
      endcase
      return pt;
   endfunction

   initial begin
      req_type            pt;
      logic [1:0]         axis;
      logic signed [31:0] offset;
      bit                 clamp;
      bit                 flip;
      logic [31:0]        junk;

      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = CSR_DEPTH_AXIS;
      csr_wdata = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed beats under reset settings: depth along y, clamped
      foreach (DIRECTED_Y[i]) begin
         pt.coord_x = (i % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
         pt.coord_y = DIRECTED_Y[i];
         pt.coord_z = ~pt.coord_x;
         issue(pt);
      end
      drain();

      // Directed wide depths: spare axis code, minimum offset, flip, no clamp
      write_settings(AXIS_SPARE, 32'h8000_0000, 1'b0, 1'b1, 32'hFFFF_FFFF);
      foreach (DIRECTED_Z[i]) begin
         pt.coord_x = $urandom;
         pt.coord_y = $urandom;
         pt.coord_z = DIRECTED_Z[i];
         issue(pt);
      end
      drain();

      // Random phases, each under its own settings
      for (int p = 0; p < PHASES; p++) begin
         case (p % 4)
            0:       axis = AXIS_X;
            1:       axis = AXIS_Y;
            2:       axis = AXIS_Z;
            default: axis = AXIS_SPARE;
         endcase
         case (p % 5)
            0:       offset = '0;
            1:       offset = 32'h7FFF_FFFF;
            2:       offset = 32'h8000_0000;
            3:       offset = $urandom;
            default: offset = $signed($urandom_range(0, 40000 * 256)) - 20000 * 256;
         endcase
         clamp  = ((p / 2) % 2) != 0;
         flip   = (p % 3) == 1;
         junk   = (p % 2) ? $urandom : 32'h0;
         write_settings(axis, offset, clamp, flip, junk);
         steady = (p == 0 || p == 5);
         for (int n = 0; n < POINTS_PER_PHASE; n++)
            issue(random_point(axis, offset, flip));
         drain();
      end

      // Let any stray result show up before the verdict
      repeat (PIPE_STAGES + 10) @(posedge clock);
      if (fault_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ filelist.f @@
src/delu_pkg.sv
src/delu_interp_lane.sv
src/depth_elastic_property_lookup_unit.sv
test/delu_property_checker.sv
test/depth_elastic_property_lookup_unit_test.sv
